FILE: design/lbg_pkg.sv
// Package for the bar-graph code generator: field widths, codes, register
// indexes and reset values. No dependencies.
package lbg_pkg;

    localparam int DEF_MAX_CELLS = 16;

    localparam int LEVEL_W = 8;
    localparam int FS_W    = 8;
    localparam int BC_W    = 5;
    localparam int CODE_W  = 6;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 8;

    localparam int DIV_STEP = 4;

    localparam int PIX_PER_CELL = 6;
    localparam logic [CODE_W-1:0] CODE_FULL  = 6'd5;
    localparam logic [CODE_W-1:0] CODE_EMPTY = 6'd32;

    localparam logic [FS_W-1:0] FS_RESET = 8'd255;
    localparam logic [BC_W-1:0] BC_RESET = 5'd16;

    typedef enum logic [0:0] {
        REG_FULL_SCALE = 1'b0,
        REG_BAR_CHARS  = 1'b1
    } t_reg_idx;

endpackage

FILE: design/lcd_bar_graph_codes.sv
// Bar-graph character code generator, top level.
// Depends on lbg_pkg and lbg_div.
//
// Usage:
//   Slave stream takes one level per transfer. For each level the block emits
//   one cell code per character cell of the bar on the master stream, cell 0
//   first, tlast on the final cell. A bar length of zero emits nothing.
//   Config port writes full_scale (index 0) or bar_chars (index 1); it is
//   always ready. The user must write it only while the block is idle;
//   the block itself does not enforce this.
// Path: input capture, product, divider stages, then the output register.
// Throughput: one cell per cycle on the output while the receiver is ready;
//   the input pipeline (multiply, then the divider at 4 quotient bits per
//   stage) accepts one level per cycle while it has room.
// Reset: pipeline empties, full_scale = 255, bar_chars = 16.
// Stall: when the receiver holds tready low, the output register keeps its
//   cell and the upstream stages fill and then deassert tready in turn;
//   nothing is dropped or repeated.
module lcd_bar_graph_codes #(
    parameter int MAX_CELLS = lbg_pkg::DEF_MAX_CELLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [lbg_pkg::LEVEL_W-1:0] i_s_axis_tdata,  // [7:0] level
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [15:0]                o_m_axis_tdata,  // [5:0] cell_code, [9:6] cell_index
    output logic                       o_m_axis_tlast,  // last_cell
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  lbg_pkg::t_reg_idx          i_cfg_index,
    input  logic [lbg_pkg::CFG_W-1:0]  i_cfg_data
);
    import lbg_pkg::*;

    localparam int CNT_W  = $clog2(MAX_CELLS + 1);
    localparam int C6_W   = $clog2(MAX_CELLS * PIX_PER_CELL + 1);
    localparam int PROD_W = $clog2(255 * MAX_CELLS * PIX_PER_CELL + 1);

    function automatic logic [CODE_W-1:0] f_code(input logic [PROD_W-1:0] p);
        if (p >= PROD_W'(CODE_FULL)) begin
            return CODE_FULL;
        end else if (p == '0) begin
            return CODE_EMPTY;
        end else begin
            return CODE_W'(p);
        end
    endfunction

    function automatic logic [PROD_W-1:0] f_next(input logic [PROD_W-1:0] p);
        if (p >= PROD_W'(PIX_PER_CELL)) begin
            return p - PROD_W'(PIX_PER_CELL);
        end else begin
            return '0;
        end
    endfunction

    // config registers
    logic [FS_W-1:0] r_full_scale;
    logic [BC_W-1:0] r_bar_chars;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FS_RESET;
            r_bar_chars  <= BC_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FULL_SCALE: r_full_scale <= i_cfg_data[FS_W-1:0];
                REG_BAR_CHARS:  r_bar_chars  <= i_cfg_data[BC_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [31:0]      w_bc32;
    logic [CNT_W-1:0] w_cells;
    logic [FS_W-1:0]  w_div;

    assign w_bc32  = 32'(r_bar_chars);
    assign w_cells = (w_bc32 > 32'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(w_bc32);
    assign w_div   = (r_full_scale == '0) ? FS_W'(1) : r_full_scale;

    // stage A: input capture
    logic              r_a_v;
    logic [LEVEL_W-1:0] r_a_level;
    logic [CNT_W-1:0]  r_a_cells;
    logic [FS_W-1:0]   r_a_div;
    // stage B: product
    logic              r_b_v;
    logic [PROD_W-1:0] r_b_prod;
    logic [CNT_W-1:0]  r_b_cells;
    logic [FS_W-1:0]   r_b_div;

    logic              w_a_en;
    logic              w_b_en;
    logic              w_div_rdy;
    logic              w_div_v;
    logic [PROD_W-1:0] w_pix;
    logic [CNT_W-1:0]  w_div_cells;
    logic              w_emit_rdy;
    logic [C6_W-1:0]   w_a_c6;

    // output stage
    logic              r_o_valid;
    logic [CODE_W-1:0] r_o_code;
    logic [CNT_W-1:0]  r_o_idx;
    logic              r_o_last;
    logic [PROD_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cells;
    logic              n_o_valid;

    assign w_emit_rdy      = !r_o_valid || (i_m_axis_tready && r_o_last);
    assign w_b_en          = !r_b_v || w_div_rdy;
    assign w_a_en          = !r_a_v || w_b_en;
    assign o_s_axis_tready = w_a_en;
    assign w_a_c6          = C6_W'(r_a_cells) * C6_W'(PIX_PER_CELL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_a_en) begin
                r_a_v <= i_s_axis_tvalid && (w_cells != '0);
            end
            if (w_b_en) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_en && i_s_axis_tvalid) begin
            r_a_level <= i_s_axis_tdata;
            r_a_cells <= w_cells;
            r_a_div   <= w_div;
        end
        if (w_b_en && r_a_v) begin
            r_b_prod  <= PROD_W'(r_a_level) * PROD_W'(w_a_c6);
            r_b_cells <= r_a_cells;
            r_b_div   <= r_a_div;
        end
    end

    lbg_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (FS_W),
        .SIDE_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_v),
        .o_ready (w_div_rdy),
        .i_num   (r_b_prod),
        .i_den   (r_b_div),
        .i_side  (r_b_cells),
        .o_valid (w_div_v),
        .i_ready (w_emit_rdy),
        .o_quo   (w_pix),
        .o_side  (w_div_cells)
    );

    // cell emitter
    always_comb begin
        n_o_valid = r_o_valid;
        if (w_emit_rdy) begin
            n_o_valid = w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_rdy && w_div_v) begin
            r_o_code <= f_code(w_pix);
            r_rem    <= f_next(w_pix);
            r_o_idx  <= '0;
            r_o_last <= (w_div_cells == CNT_W'(1));
            r_cells  <= w_div_cells;
        end else if (r_o_valid && i_m_axis_tready && !r_o_last) begin
            r_o_code <= f_code(r_rem);
            r_rem    <= f_next(r_rem);
            r_o_idx  <= r_o_idx + CNT_W'(1);
            r_o_last <= (r_o_idx + CNT_W'(2) == r_cells);
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {6'b0, IDX_W'(r_o_idx), r_o_code};
    assign o_m_axis_tlast  = r_o_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_idx < r_cells))
        else $error("cell index beyond bar length");

    a_last_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_last == (r_o_idx + CNT_W'(1) == r_cells)))
        else $error("tlast not on final cell");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_code == CODE_FULL || r_o_code == CODE_EMPTY ||
                       (r_o_code >= CODE_W'(1) && r_o_code <= CODE_W'(4))))
        else $error("illegal cell code");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_m_axis_tready && !r_o_last) |=>
            (r_o_valid && r_o_idx == $past(r_o_idx) + CNT_W'(1)))
        else $error("row broken after non-final transfer");

endmodule

FILE: design/lbg_div.sv
// Pipelined restoring divider, DIV_STEP quotient bits per stage, with a
// sideband carried along. Depends on lbg_pkg.
module lbg_div #(
    parameter int NUM_W  = 17,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    import lbg_pkg::*;

    localparam int NSTG = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int NPAD = NSTG * DIV_STEP;

    function automatic logic [DEN_W+NPAD-1:0] f_steps(
        input logic [DEN_W-1:0] rem,
        input logic [NPAD-1:0]  n,
        input logic [DEN_W-1:0] d
    );
        logic [DEN_W-1:0] r;
        logic [NPAD-1:0]  q;
        logic [DEN_W:0]   t;
        r = rem;
        q = n;
        for (int k = 0; k < DIV_STEP; k++) begin
            t = {r, q[NPAD-1]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                q = {q[NPAD-2:0], 1'b1};
            end else begin
                q = {q[NPAD-2:0], 1'b0};
            end
            r = t[DEN_W-1:0];
        end
        return {r, q};
    endfunction

    logic              r_v    [NSTG];
    logic [DEN_W-1:0]  r_rem  [NSTG];
    logic [NPAD-1:0]   r_n    [NSTG];
    logic [DEN_W-1:0]  r_d    [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];

    logic              w_rdy  [NSTG+1];
    logic              w_iv   [NSTG];
    logic [DEN_W-1:0]  w_irem [NSTG];
    logic [NPAD-1:0]   w_in   [NSTG];
    logic [DEN_W-1:0]  w_id   [NSTG];
    logic [SIDE_W-1:0] w_is   [NSTG];

    always_comb begin
        w_rdy[NSTG] = i_ready;
        for (int g = NSTG - 1; g >= 0; g--) begin
            w_rdy[g] = !r_v[g] || w_rdy[g+1];
        end
        w_iv[0]   = i_valid;
        w_irem[0] = '0;
        w_in[0]   = NPAD'(i_num);
        w_id[0]   = i_den;
        w_is[0]   = i_side;
        for (int g = 1; g < NSTG; g++) begin
            w_iv[g]   = r_v[g-1];
            w_irem[g] = r_rem[g-1];
            w_in[g]   = r_n[g-1];
            w_id[g]   = r_d[g-1];
            w_is[g]   = r_side[g-1];
        end
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (w_rdy[g]) begin
                r_v[g] <= w_iv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[g] && w_iv[g]) begin
                {r_rem[g], r_n[g]} <= f_steps(w_irem[g], w_in[g], w_id[g]);
                r_d[g]             <= w_id[g];
                r_side[g]          <= w_is[g];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NSTG-1];
    assign o_quo   = r_n[NSTG-1][NUM_W-1:0];
    assign o_side  = r_side[NSTG-1];

endmodule

FILE: bench/lbg_checker.sv
// Checker for the bar-graph code generator: watches the level stream, the
// config port and the cell-code stream, predicts each row and compares.
// Depends on lbg_pkg.
`timescale 1ns / 1ps

module lbg_checker #(
    parameter int MAX_CELLS = lbg_pkg::DEF_MAX_CELLS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    input  logic                        i_s_ready,
    input  logic [lbg_pkg::LEVEL_W-1:0] i_s_data,  // [7:0] level
    input  logic                        i_m_valid,
    input  logic                        i_m_ready,
    input  logic [15:0]                 i_m_data,  // [5:0] cell_code, [9:6] cell_index
    input  logic                        i_m_last,  // last_cell
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  lbg_pkg::t_reg_idx           i_cfg_index,
    input  logic [lbg_pkg::CFG_W-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import lbg_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_cell;

    t_cell             cells_due[$];
    logic [FS_W-1:0]   full_scale;
    logic [BC_W-1:0]   bar_chars;
    int                fails;

    assign o_fail_count = fails;

    initial fails = 0;

    function automatic void queue_bar_cells(input logic [LEVEL_W-1:0] level);
        int unsigned divisor;
        int unsigned ncells;
        int unsigned pixels;
        int unsigned start;
        t_cell       c;
        divisor = (full_scale == 0) ? 1 : full_scale;
        ncells  = (bar_chars > MAX_CELLS) ? MAX_CELLS : bar_chars;
        pixels  = (level * ncells * PIX_PER_CELL) / divisor;
        for (int k = 0; k < ncells; k++) begin
            start = k * PIX_PER_CELL;
            if (start + 5 <= pixels) begin
                c.code = CODE_FULL;
            end else if (start >= pixels) begin
                c.code = CODE_EMPTY;
            end else begin
                c.code = CODE_W'(pixels % PIX_PER_CELL);
            end
            c.idx  = IDX_W'(k);
            c.last = (k + 1 == ncells);
            cells_due.push_back(c);
        end
    endfunction

    always @(posedge i_clk) begin
        t_cell want;
        if (!i_rst_n) begin
            full_scale = FS_RESET;
            bar_chars  = BC_RESET;
            cells_due.delete();
        end else begin
            if (i_m_valid && i_m_ready) begin
                if (cells_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected cell transfer, actual data %h last %b",
                             $time, i_m_data, i_m_last);
                end else begin
                    want = cells_due.pop_front();
                    if (i_m_data[5:0] !== want.code) begin
                        fails++;
                        $display("%0t: cell_code expected %0d actual %0d",
                                 $time, want.code, i_m_data[5:0]);
                    end
                    if (i_m_data[9:6] !== want.idx) begin
                        fails++;
                        $display("%0t: cell_index expected %0d actual %0d",
                                 $time, want.idx, i_m_data[9:6]);
                    end
                    if (i_m_data[15:10] !== '0) begin
                        fails++;
                        $display("%0t: tdata pad expected 0 actual %h",
                                 $time, i_m_data[15:10]);
                    end
                    if (i_m_last !== want.last) begin
                        fails++;
                        $display("%0t: last_cell expected %b actual %b",
                                 $time, want.last, i_m_last);
                    end
                end
            end
            if (i_s_valid && i_s_ready) begin
                queue_bar_cells(i_s_data);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FULL_SCALE: full_scale = i_cfg_data[FS_W-1:0];
                    REG_BAR_CHARS:  bar_chars  = i_cfg_data[BC_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = cells_due.size();
    end

endmodule

FILE: bench/lcd_bar_graph_codes_tb.sv
// Testbench top for lcd_bar_graph_codes: clock, reset, level and config
// stimulus with random idling on both streams, and the final verdict.
// Depends on lbg_pkg, lcd_bar_graph_codes and lbg_checker.
`timescale 1ns / 1ps

module lcd_bar_graph_codes_tb;
    import lbg_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 30;

    logic               i_clk;
    logic               rst_n;
    logic               s_valid;
    logic               s_ready;
    logic [LEVEL_W-1:0] s_data;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_data;
    logic               m_last;
    logic               cfg_valid;
    logic               cfg_ready;
    t_reg_idx           cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    int                 fail_count;
    int                 pending;
    int                 cycles;
    logic               quiet;
    logic [FS_W-1:0]    cur_fs;

    lcd_bar_graph_codes u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    lbg_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_m_last     (m_last),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        m_ready = quiet ? 1'b1 : ($urandom_range(99) >= 23);
    end

    task automatic send_level(input logic [LEVEL_W-1:0] level);
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < 23) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = level;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    // hold the sender until every cell has come, then let the pipeline drain
    task automatic drain();
        @(negedge i_clk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        if (idx == REG_FULL_SCALE) cur_fs = data;
    endtask

    task automatic set_bar(input logic [FS_W-1:0] fs, input logic [BC_W-1:0] bc);
        drain();
        write_reg(REG_FULL_SCALE, fs);
        write_reg(REG_BAR_CHARS, {3'($urandom_range(7)), bc});
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(255);
            1: v = int'(cur_fs) + $urandom_range(6) - 3;
            2: v = $urandom_range(cur_fs);
            default: begin
                case ($urandom_range(2))
                    0: v = 0;
                    1: v = 255;
                    default: v = cur_fs;
                endcase
            end
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return LEVEL_W'(v);
    endfunction

    initial begin
        logic [FS_W-1:0] fs;
        logic [BC_W-1:0] bc;
        rst_n     = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FULL_SCALE;
        cfg_data  = '0;
        quiet     = 1'b0;
        cur_fs    = FS_RESET;
        repeat (11) @(negedge i_clk);
        rst_n = 1'b1;

        // reset settings: full scale 255, 16 cells
        send_level(8'd0);
        send_level(8'd255);
        send_level(8'd128);
        send_level(8'd1);
        send_level(8'd254);
        // zero full scale acts as one
        set_bar(8'd0, 5'd16);
        send_level(8'd0);
        send_level(8'd1);
        send_level(8'd200);
        // zero bar length: no cells
        set_bar(8'd1, 5'd0);
        send_level(8'd5);
        send_level(8'd0);
        // bar length above the maximum is clamped
        drain();
        write_reg(REG_FULL_SCALE, 8'd100);
        write_reg(REG_BAR_CHARS, 8'hFF);
        send_level(8'd50);
        send_level(8'd99);
        send_level(8'd100);
        // partial cells
        set_bar(8'd7, 5'd3);
        send_level(8'd1);
        send_level(8'd2);
        send_level(8'd3);
        send_level(8'd5);
        send_level(8'd7);
        send_level(8'd8);
        // single cell
        set_bar(8'd200, 5'd1);
        send_level(8'd100);
        send_level(8'd199);

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(5))
                0: fs = 8'd0;
                1: fs = 8'd1;
                2: fs = 8'd255;
                default: fs = FS_W'($urandom_range(255));
            endcase
            case ($urandom_range(9))
                0: bc = 5'd0;
                1: bc = BC_W'($urandom_range(31, 17));
                2: bc = 5'd16;
                3: bc = 5'd1;
                default: bc = BC_W'($urandom_range(16, 1));
            endcase
            set_bar(fs, bc);
            quiet = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(39) == 0) drain();
                send_level(pick_level());
            end
            quiet = 1'b0;
        end

        drain();
        if (pending != 0) $display("%0t: %0d cells never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
